/* rtl/gf256_multiply_inverse_core_defines.svh */
// ----------------------------------------------------------------------------
// GF(2^8) multiply/inverse core: assertion macros
// Shared helpers for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef GF256_MULTIPLY_INVERSE_CORE_DEFINES_SVH
`define GF256_MULTIPLY_INVERSE_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define GFMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked implication checked on every edge, reset included.
`define GFMI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/gfmi_pkg.sv */
// ----------------------------------------------------------------------------
// GF(2^8) multiply/inverse core: package
// Widths, the pipeline stage record and the field helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package gfmi_pkg;

  localparam int unsigned ELEM_W    = 8;
  localparam int unsigned PROD_W    = 2 * ELEM_W - 1;
  localparam int unsigned NUM_ELIM  = ELEM_W;
  localparam int unsigned NUM_STG   = NUM_ELIM + 1;
  localparam logic [ELEM_W:0] FIELD_POLY_RESET = 9'h11B;

  typedef enum logic {
    CMD_MUL = 1'b0,
    CMD_INV = 1'b1
  } cmd_t;

  // One equation of the linear system: bits 7..0 are coefficients, bit 8 the
  // right-hand side.
  typedef logic [ELEM_W:0] row_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [PROD_W-1:0]       prod;
    row_t [ELEM_W-1:0]       rows;
    logic                    singular;
  } gfmi_stage_t;

  function automatic logic [ELEM_W-1:0] gf_xtime(input logic [ELEM_W-1:0] v,
                                                 input logic [ELEM_W-1:0] taps);
    return {v[ELEM_W-2:0], 1'b0} ^ (v[ELEM_W-1] ? taps : '0);
  endfunction

  function automatic logic [PROD_W-1:0] gf_clmul(input logic [ELEM_W-1:0] a,
                                                 input logic [ELEM_W-1:0] b);
    logic [PROD_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < ELEM_W; k++) begin
      if (a[k]) begin
        acc = acc ^ ({{(PROD_W-ELEM_W){1'b0}}, b} << k);
      end
    end
    return acc;
  endfunction

  function automatic logic [ELEM_W-1:0] gf_reduce(input logic [PROD_W-1:0] p,
                                                  input logic [ELEM_W-1:0] taps);
    logic [PROD_W-1:0] r;
    logic [ELEM_W:0]   poly;
    r    = p;
    poly = {1'b1, taps};
    for (int k = PROD_W - 1; k >= ELEM_W; k--) begin
      if (r[k]) begin
        r = r ^ ({{(PROD_W-ELEM_W-1){1'b0}}, poly} << (k - ELEM_W));
      end
    end
    return r[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/gfmi_build.sv */
// ----------------------------------------------------------------------------
// GF(2^8) multiply/inverse core: front stage logic
// Forms the carry-less product and the system A * x = 1 for the inverse.
// ----------------------------------------------------------------------------
`default_nettype none

module gfmi_build
  import gfmi_pkg::*;
(
  input  cmd_t              cmd,
  input  logic [ELEM_W-1:0] operand_a,
  input  logic [ELEM_W-1:0] operand_b,
  input  logic [ELEM_W-1:0] taps,
  output gfmi_stage_t       stage_out
);

  // Column j of the multiply-by-A matrix is A * x^j reduced.
  logic [ELEM_W-1:0] col [ELEM_W];

  always_comb begin
    col[0] = operand_a;
    for (int j = 1; j < ELEM_W; j++) begin
      col[j] = gf_xtime(col[j-1], taps);
    end
  end

  always_comb begin
    stage_out.cmd      = cmd;
    stage_out.prod     = gf_clmul(operand_a, operand_b);
    stage_out.singular = 1'b0;
    for (int i = 0; i < ELEM_W; i++) begin
      for (int j = 0; j < ELEM_W; j++) begin
        stage_out.rows[i][j] = col[j][i];
      end
      stage_out.rows[i][ELEM_W] = (i == 0);
    end
  end

endmodule

`default_nettype wire

/* rtl/gfmi_elim.sv */
// ----------------------------------------------------------------------------
// GF(2^8) multiply/inverse core: elimination step
// Clears one column of the system by Gauss-Jordan elimination over GF(2).
// ----------------------------------------------------------------------------
`default_nettype none

module gfmi_elim
  import gfmi_pkg::*;
#(
  parameter int unsigned COL = 0
) (
  input  gfmi_stage_t stage_in,
  output gfmi_stage_t stage_out
);

  localparam logic [2:0] COL_IDX = 3'(COL);

  always_comb begin : elim
    logic              found;
    logic [2:0]        piv;
    row_t [ELEM_W-1:0] r;
    stage_out = stage_in;
    found     = 1'b0;
    piv       = COL_IDX;
    // Scan downward so the lowest eligible row ends up as pivot.
    for (int i = ELEM_W - 1; i >= int'(COL); i--) begin
      if (stage_in.rows[i][COL]) begin
        found = 1'b1;
        piv   = 3'(i);
      end
    end
    r          = stage_in.rows;
    r[COL_IDX] = stage_in.rows[piv];
    r[piv]     = stage_in.rows[COL_IDX];
    if (found) begin
      for (int i = 0; i < ELEM_W; i++) begin
        if (i != int'(COL) && r[i][COL]) begin
          r[i] = r[i] ^ r[COL_IDX];
        end
      end
    end
    stage_out.rows     = r;
    stage_out.singular = stage_in.singular | ~found;
  end

endmodule

`default_nettype wire

/* rtl/gf256_multiply_inverse_core.sv */
// ----------------------------------------------------------------------------
// GF(2^8) multiply/inverse core: top level
// Pipelined field multiplier and inverter with a configurable polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) takes one item per cycle while
//   in_stall is low: a command, operand_a and operand_b. The output channel
//   (out_valid/out_stall) returns one field_result per item, in order.
//   Multiply returns A*B reduced by the field polynomial. Inverse returns the
//   byte X with A*X = 1, or 0 when A has no inverse (A = 0 included).
//   The inverse is found by solving the 8x8 system over GF(2) with one
//   elimination stage per column. While in_stall is low, a new item can be
//   taken every cycle. When the receiver stalls, the output register holds
//   its item and the pipeline fills its empty stages; in_stall rises only
//   once every stage is occupied. Reset empties the pipeline and loads the
//   polynomial 0x11B. cfg_wr_en writes the polynomial from cfg_wr_data; the
//   x^8 term is always taken as one. Write it only while the core is empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf256_multiply_inverse_core_defines.svh"

module gf256_multiply_inverse_core
  import gfmi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [ELEM_W:0]   cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [ELEM_W-1:0] operand_a,
  input  logic [ELEM_W-1:0] operand_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ELEM_W-1:0] field_result
);

  // Only the reduction taps are stored; the leading term is implied.
  logic [ELEM_W-1:0] taps;

  gfmi_stage_t       build_out;
  gfmi_stage_t       stg      [NUM_STG];
  gfmi_stage_t       nxt      [NUM_STG];
  gfmi_stage_t       elim_out [NUM_ELIM];
  logic [NUM_STG-1:0] stg_v;
  logic [NUM_STG-1:0] adv;
  logic               adv_out;
  logic [ELEM_W-1:0]  inv_x;
  logic [ELEM_W-1:0]  result_next;
  logic               last_identity;
  logic               last_inv_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= FIELD_POLY_RESET[ELEM_W-1:0];
    end else if (cfg_wr_en) begin
      taps <= cfg_wr_data[ELEM_W-1:0];
    end
  end

  gfmi_build u_build (
    .cmd       (cmd_t'(cmd)),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .taps      (taps),
    .stage_out (build_out)
  );

  for (genvar k = 0; k < NUM_ELIM; k++) begin : g_elim
    gfmi_elim #(
      .COL (k)
    ) u_elim (
      .stage_in  (stg[k]),
      .stage_out (elim_out[k])
    );
  end

  // The product is reduced alongside the first elimination step.
  always_comb begin
    nxt[0] = build_out;
    for (int k = 1; k < NUM_STG; k++) begin
      nxt[k] = elim_out[k-1];
    end
    nxt[1].prod = {{(PROD_W-ELEM_W){1'b0}}, gf_reduce(stg[0].prod, taps)};
  end

  always_comb begin
    adv_out            = ~out_valid | ~out_stall;
    adv[NUM_STG-1]     = ~stg_v[NUM_STG-1] | adv_out;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      adv[k] = ~stg_v[k] | adv[k+1];
    end
  end

  assign in_stall = ~adv[0];

  always_comb begin
    for (int j = 0; j < ELEM_W; j++) begin
      inv_x[j] = stg[NUM_STG-1].rows[j][ELEM_W];
    end
    if (stg[NUM_STG-1].cmd == CMD_INV) begin
      result_next = stg[NUM_STG-1].singular ? '0 : inv_x;
    end else begin
      result_next = stg[NUM_STG-1].prod[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv[0]) begin
        stg_v[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (adv[k]) begin
          stg_v[k] <= stg_v[k-1];
        end
      end
      if (adv_out) begin
        out_valid <= stg_v[NUM_STG-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STG; k++) begin
      if (adv[k]) begin
        stg[k] <= nxt[k];
      end
    end
    if (adv_out) begin
      field_result <= result_next;
    end
  end

  // A solved, nonsingular system must have reduced to the identity matrix.
  always_comb begin
    last_identity = 1'b1;
    for (int i = 0; i < ELEM_W; i++) begin
      if (stg[NUM_STG-1].rows[i][ELEM_W-1:0] != (ELEM_W'(1) << i)) begin
        last_identity = 1'b0;
      end
    end
  end

  assign last_inv_ok = stg_v[NUM_STG-1] && (stg[NUM_STG-1].cmd == CMD_INV)
                       && !stg[NUM_STG-1].singular;

  `GFMI_ASSERT(a_stall_only_when_full, in_stall |-> (&stg_v), "input stalled with a free stage")
  `GFMI_ASSERT(a_last_stage_drains, (stg_v[NUM_STG-1] && adv_out) |=> out_valid, "item lost")
  `GFMI_ASSERT(a_inverse_solved, last_inv_ok |-> last_identity, "no identity after elimination")
  `GFMI_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && stg_v == '0), "pipeline not empty")

endmodule

`default_nettype wire

/* bench/gf256_multiply_inverse_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GF(2^8) multiply/inverse core: testbench
// Sends multiply and inverse items under several field polynomials, with
// random gaps on the input side and random stalls on the output side. Each
// result is compared in order with the value that a bit-level model of the
// field arithmetic, held in a small scoreboard class, works out.
// ----------------------------------------------------------------------------

module gf256_multiply_inverse_core_test;
  import gfmi_pkg::*;

  typedef logic [PROD_W-1:0] wide_t;

  typedef struct {
    cmd_t              op;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic [ELEM_W-1:0] result;
  } gf_expect_t;

  class gf_result_scoreboard;
    logic [ELEM_W:0] field_poly;
    gf_expect_t      expected_results[$];
    int              fails;

    function new();
      field_poly = FIELD_POLY_RESET;
      fails      = 0;
    endfunction

    function void set_field_poly(logic [ELEM_W:0] poly);
      field_poly = poly;
    endfunction

    // The x^8 coefficient is always taken as one; only the low eight bits
    // of the register act as reduction taps.
    function logic [ELEM_W-1:0] field_product(logic [ELEM_W-1:0] a,
                                              logic [ELEM_W-1:0] b);
      wide_t acc;
      wide_t modulus;
      acc     = '0;
      modulus = wide_t'({1'b1, field_poly[ELEM_W-1:0]});
      for (int k = 0; k < ELEM_W; k++) begin
        if (a[k]) begin
          acc = acc ^ (wide_t'(b) << k);
        end
      end
      for (int k = PROD_W - 1; k >= ELEM_W; k--) begin
        if (acc[k]) begin
          acc = acc ^ (modulus << (k - ELEM_W));
        end
      end
      return acc[ELEM_W-1:0];
    endfunction

    function logic [ELEM_W-1:0] field_inverse(logic [ELEM_W-1:0] a);
      for (int x = 1; x < 256; x++) begin
        if (field_product(a, 8'(x)) == 8'h01) begin
          return 8'(x);
        end
      end
      return '0;
    endfunction

    function void note_item(cmd_t op, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
      gf_expect_t entry;
      entry.op     = op;
      entry.a      = a;
      entry.b      = b;
      entry.result = (op == CMD_MUL) ? field_product(a, b) : field_inverse(a);
      expected_results.push_back(entry);
    endfunction

    function void check_result(logic [ELEM_W-1:0] actual);
      gf_expect_t entry;
      if (expected_results.size() == 0) begin
        $error("field_result: no item outstanding, actual %02h", actual);
        fails++;
      end else begin
        entry = expected_results.pop_front();
        if (actual !== entry.result) begin
          $error("field_result (%s a=%02h b=%02h poly=%03h): expected %02h, actual %02h",
                 entry.op.name(), entry.a, entry.b, field_poly, entry.result, actual);
          fails++;
        end
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_wr_en    = 1'b0;
  logic [ELEM_W:0]   cfg_wr_data  = '0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic              cmd          = 1'b0;
  logic [ELEM_W-1:0] operand_a    = '0;
  logic [ELEM_W-1:0] operand_b    = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [ELEM_W-1:0] field_result;

  gf_result_scoreboard sb = new();

  gf256_multiply_inverse_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .field_result (field_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Values read here are the ones present just before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_item(cmd_t'(cmd), operand_a, operand_b);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(field_result);
      end
    end
  end

  // Output stalls come in runs: none at all, light, even, or heavy.
  initial begin
    int run_len;
    int mode;
    forever begin
      run_len = $urandom_range(1, 40);
      mode    = $urandom_range(0, 3);
      repeat (run_len) begin
        @(posedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_stall <= ($urandom_range(0, 9) != 0);
          end
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("gf256_multiply_inverse_core: mismatch");
    $finish;
  end

  function automatic int next_gap(bit gaps_on);
    int roll;
    if (!gaps_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_byte();
    case ($urandom_range(0, 15))
      0, 1: return 8'h00;
      2, 3: return 8'hFF;
      4:    return 8'h01;
      5:    return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(cmd_t op, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    operand_a <= a;
    operand_b <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_field_poly(logic [ELEM_W:0] poly);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= poly;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_field_poly(poly);
  endtask

  initial begin
    logic [ELEM_W:0] poly;
    bit              gaps_on;
    cmd_t            op;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset polynomial: operand extremes, zero products and inverses.
    send_item(CMD_MUL, 8'h00, 8'h00, 0);
    send_item(CMD_MUL, 8'hFF, 8'hFF, 0);
    send_item(CMD_MUL, 8'h01, 8'hFF, 0);
    send_item(CMD_MUL, 8'hFF, 8'h01, 1);
    send_item(CMD_MUL, 8'h80, 8'h80, 0);
    send_item(CMD_MUL, 8'h53, 8'hCA, 0);
    send_item(CMD_MUL, 8'h00, 8'hA5, 2);
    send_item(CMD_INV, 8'h00, 8'hFF, 0);
    send_item(CMD_INV, 8'h01, 8'h00, 0);
    send_item(CMD_INV, 8'hFF, 8'h5A, 0);
    send_item(CMD_INV, 8'h53, 8'hFF, 3);
    send_item(CMD_INV, 8'h80, 8'h00, 0);
    send_item(CMD_INV, 8'h02, 8'h00, 0);
    drain_results();

    // x^8 alone is reducible: even elements have no inverse and some
    // nonzero products reduce to zero.
    write_field_poly(9'h100);
    send_item(CMD_INV, 8'h02, 8'h00, 0);
    send_item(CMD_INV, 8'h01, 8'hFF, 0);
    send_item(CMD_MUL, 8'h80, 8'h02, 0);
    send_item(CMD_MUL, 8'hFF, 8'hFF, 0);
    send_item(CMD_INV, 8'hFF, 8'h00, 0);
    drain_results();

    // Register value without the x^8 bit.
    write_field_poly(9'h01B);
    send_item(CMD_MUL, 8'hFF, 8'hFF, 0);
    send_item(CMD_INV, 8'h53, 8'h00, 0);
    send_item(CMD_MUL, 8'h80, 8'h80, 0);
    drain_results();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: poly = 9'h11D;
        1: poly = 9'h1FF;
        3: poly = 9'h100;
        5: poly = 9'h11B;
        6: poly = 9'h01B;
        default: poly = 9'($urandom_range(256, 511));
      endcase
      write_field_poly(poly);
      gaps_on = (phase != 2);
      for (int n = 0; n < 138; n++) begin
        if (phase == 4 && n == 70) begin
          drain_results();
        end
        op = $urandom_range(0, 1) ? CMD_INV : CMD_MUL;
        send_item(op, pick_byte(), pick_byte(), next_gap(gaps_on));
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("gf256_multiply_inverse_core: match");
    end else begin
      $display("gf256_multiply_inverse_core: mismatch");
    end
    $finish;
  end

endmodule
